// ===== hdl/vcmc_pkg.sv =====
// shared types, constants and helper functions of the vector clock block
package vcmc_pkg;

    localparam int NODES      = 16;
    localparam int COUNT_BITS = 31;
    localparam int ADDR_W     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int TOTAL_W    = $clog2(NODES + 1);

    localparam int KIND_W  = 2;
    localparam int ID_W    = 4;
    localparam int RC_W    = 31;
    localparam int LC_W    = 31;
    localparam int ORDER_W = 2;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [TOTAL_W-1:0]    t_total;

    localparam t_count CNT_MAX   = '1;
    localparam t_total TOTAL_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECV  = 2'd2;

    localparam logic [ORDER_W-1:0] ORD_BEFORE = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_AFTER  = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_CONC   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   node_id;
        logic [RC_W-1:0]   remote_count;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [LC_W-1:0]    local_count;
        logic [ORDER_W-1:0] order;
        logic               is_receive;
    } t_out_item;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return int'(id) < NODES;
    endfunction

    function automatic t_count sat_inc(input t_count v);
        return (v == CNT_MAX) ? v : v + t_count'(1);
    endfunction

endpackage

// ===== hdl/vcmc_ram.sv =====
// generic ram, one write port and two registered read ports
module vcmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr_a,
    output logic [WIDTH-1:0]                 o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr_b,
    output logic [WIDTH-1:0]                 o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ===== hdl/vector_clock_merge_compare.sv =====
// top level of the vector clock keeper with merge and compare
//
// input channel: an item (i_item) is taken at a clock edge where start is
// high and busy is low. kind event or send bumps the local counter and
// returns it; kind receive is one entry of a remote vector, a run of such
// entries closed by last returns the ordering of the local clock as it stood
// before the run against the remote vector. kind 3 is dropped silently.
// for each item the counter ram is read at the accept edge and written back in
// the following cycle, so busy is high for one cycle after every accepted item
// and no new item is taken until the last one has been written back.
// result: o_strobe is high for exactly one cycle, on the cycle after the
// write-back, and marks o_result as valid; the receiver cannot hold results
// off and no result is dropped.
// config: i_cfg_data carries local_id, written at an edge where i_cfg_valid
// and o_cfg_ready are high; write it only while the block is idle.
// reset (i_rst_n low, synchronous) clears all counters and present marks via
// per-entry valid bits at once, so the block is ready the cycle after reset.
module vector_clock_merge_compare (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  vcmc_pkg::t_in_item    i_item,
    output logic                  o_strobe,
    output vcmc_pkg::t_out_item   o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [vcmc_pkg::ID_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    vcmc_pkg::t_in_item           r_item, n_item;
    logic [vcmc_pkg::ID_W-1:0]    r_local_id;
    logic [vcmc_pkg::NODES-1:0]   r_marks, n_marks;
    logic [vcmc_pkg::NODES-1:0]   r_written, n_written;
    vcmc_pkg::t_total             r_pt, n_pt;
    vcmc_pkg::t_total             r_ct, n_ct;
    logic                         r_lg, n_lg;
    logic                         r_rg, n_rg;
    logic                         r_run_open, n_run_open;
    logic                         r_strobe, n_strobe;
    vcmc_pkg::t_out_item          r_result, n_result;

    logic                         accept;
    logic                         lid_ok;
    vcmc_pkg::t_addr              lid_addr;
    vcmc_pkg::t_addr              item_addr;
    logic                         item_is_local;
    vcmc_pkg::t_count             ram_a, ram_b;
    vcmc_pkg::t_count             cur_a, cur_b;
    vcmc_pkg::t_count             rc_sat;
    vcmc_pkg::t_count             c_val;
    vcmc_pkg::t_count             loc_val;
    vcmc_pkg::t_total             pop;
    logic                         wr_en;
    vcmc_pkg::t_addr              wr_addr;
    vcmc_pkg::t_count             wr_data;

    assign busy        = (r_state == S_EXEC);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    assign lid_ok        = vcmc_pkg::id_ok(r_local_id);
    assign lid_addr      = vcmc_pkg::ADDR_W'(r_local_id);
    assign item_addr     = vcmc_pkg::ADDR_W'(r_item.node_id);
    assign item_is_local = lid_ok && (item_addr == lid_addr);

    assign cur_a  = r_written[item_addr] ? ram_a : '0;
    assign cur_b  = r_written[lid_addr] ? ram_b : '0;
    assign rc_sat = (64'(r_item.remote_count) > 64'(vcmc_pkg::CNT_MAX)) ?
                    vcmc_pkg::CNT_MAX : vcmc_pkg::COUNT_BITS'(r_item.remote_count);

    // ids present when a run opens, local id always counted
    always_comb begin
        pop = '0;
        for (int i = 0; i < vcmc_pkg::NODES; i++) begin
            pop = pop + vcmc_pkg::t_total'(r_marks[i] ||
                  (lid_ok && (vcmc_pkg::ADDR_W'(i) == lid_addr)));
        end
    end

    vcmc_ram #(
        .WIDTH (vcmc_pkg::COUNT_BITS),
        .DEPTH (vcmc_pkg::NODES)
    ) u_counts (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (vcmc_pkg::ADDR_W'(i_item.node_id)),
        .o_rd_data_a (ram_a),
        .i_rd_addr_b (lid_addr),
        .o_rd_data_b (ram_b)
    );

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_marks    = r_marks;
        n_written  = r_written;
        n_pt       = r_pt;
        n_ct       = r_ct;
        n_lg       = r_lg;
        n_rg       = r_rg;
        n_run_open = r_run_open;
        n_strobe   = 1'b0;
        n_result   = r_result;
        wr_en      = 1'b0;
        wr_addr    = item_addr;
        wr_data    = rc_sat;
        c_val      = cur_a;
        loc_val    = cur_b;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_item.kind)
                    vcmc_pkg::KIND_EVENT, vcmc_pkg::KIND_SEND: begin
                        wr_en   = lid_ok;
                        wr_addr = lid_addr;
                        wr_data = vcmc_pkg::sat_inc(cur_b);
                        n_strobe = 1'b1;
                        n_result.local_count = lid_ok ? vcmc_pkg::LC_W'(wr_data) : '0;
                        n_result.order       = vcmc_pkg::ORD_BEFORE;
                        n_result.is_receive  = 1'b0;
                    end
                    vcmc_pkg::KIND_RECV: begin
                        if (!r_run_open) begin
                            n_pt = pop;
                            n_ct = '0;
                            n_lg = 1'b0;
                            n_rg = 1'b0;
                        end
                        n_run_open = 1'b1;
                        if (vcmc_pkg::id_ok(r_item.node_id)) begin
                            wr_en = 1'b1;
                            if (r_marks[item_addr] || item_is_local) begin
                                if (n_ct != vcmc_pkg::TOTAL_MAX) begin
                                    n_ct = n_ct + vcmc_pkg::t_total'(1);
                                end
                                if (c_val > rc_sat) begin
                                    n_lg = 1'b1;
                                end else if (c_val < rc_sat) begin
                                    n_rg = 1'b1;
                                end
                                if (item_is_local) begin
                                    c_val = vcmc_pkg::sat_inc(c_val);
                                end
                                wr_data = (c_val > rc_sat) ? c_val : rc_sat;
                            end else begin
                                n_rg = 1'b1;
                                wr_data = rc_sat;
                                n_marks[item_addr] = 1'b1;
                            end
                            if (item_is_local) begin
                                loc_val = wr_data;
                            end
                        end
                        if (r_item.last) begin
                            if (n_pt > n_ct) begin
                                n_lg = 1'b1;
                            end
                            n_run_open = 1'b0;
                            n_strobe   = 1'b1;
                            n_result.local_count = lid_ok ? vcmc_pkg::LC_W'(loc_val) : '0;
                            n_result.is_receive  = 1'b1;
                            if (!n_lg) begin
                                n_result.order = vcmc_pkg::ORD_BEFORE;
                            end else if (!n_rg) begin
                                n_result.order = vcmc_pkg::ORD_AFTER;
                            end else begin
                                n_result.order = vcmc_pkg::ORD_CONC;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (wr_en) begin
                    n_written[wr_addr] = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_local_id <= '0;
            r_marks    <= '0;
            r_written  <= '0;
            r_pt       <= '0;
            r_ct       <= '0;
            r_lg       <= 1'b0;
            r_rg       <= 1'b0;
            r_run_open <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_marks    <= n_marks;
            r_written  <= n_written;
            r_pt       <= n_pt;
            r_ct       <= n_ct;
            r_lg       <= n_lg;
            r_rg       <= n_rg;
            r_run_open <= n_run_open;
            r_strobe   <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_local_id <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
    end

endmodule

// ===== tb/tb_vector_clock_merge_compare.sv =====
// testbench for the vector clock merge and compare block: directed table, then random traffic
`timescale 1ns / 1ps

module tb_vector_clock_merge_compare;

    localparam logic [vcmc_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam vcmc_pkg::t_count    TOP       = vcmc_pkg::CNT_MAX;
    localparam vcmc_pkg::t_out_item NO_WANT   = '0;
    localparam int                  PHASES    = 6;
    localparam int                  PER_PHASE = 300;

    typedef struct packed {
        vcmc_pkg::t_in_item  item;
        logic                typed;
        vcmc_pkg::t_out_item want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    vcmc_pkg::t_in_item            i_item;
    logic                          o_strobe;
    vcmc_pkg::t_out_item           o_result;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [vcmc_pkg::ID_W-1:0]     i_cfg_data;

    // model state of the clock
    vcmc_pkg::t_count              vc_count [vcmc_pkg::NODES];
    logic                          vc_seen [vcmc_pkg::NODES];
    logic [vcmc_pkg::ID_W-1:0]     own_id;
    int                            base_present;
    int                            run_hits;
    bit                            mine_ahead;
    bit                            theirs_ahead;
    bit                            in_run;

    vcmc_pkg::t_out_item           due_results[$];
    int                            run_ids[$];
    int                            mismatches;
    int                            items_sent;
    int                            results_seen;
    int                            runs_closed;
    int                            settings_used;
    bit                            calm;

    // directed steps, owner id 0 after reset
    t_row steps [23] = '{
        {vcmc_pkg::KIND_EVENT, 4'd0,  31'd0, 1'b0, 1'b1, 31'd1, vcmc_pkg::ORD_BEFORE, 1'b0},
        {vcmc_pkg::KIND_SEND,  4'd0,  31'd0, 1'b0, 1'b1, 31'd2, vcmc_pkg::ORD_BEFORE, 1'b0},
        {KIND_NONE,            4'd15, TOP,   1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd5,  TOP,   1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd0,  31'd7, 1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_EVENT, 4'd15, TOP,   1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd5,  TOP,   1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd15, 31'd0, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd5,  31'd0, 1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd3,  31'd4, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd3,  31'd2, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd3,  31'd9, 1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd7,  31'd1, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_SEND,  4'd0,  31'd0, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd0,  31'd0, 1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd0,  TOP,   1'b1, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_EVENT, 4'd0,  31'd0, 1'b0, 1'b1, TOP, vcmc_pkg::ORD_BEFORE, 1'b0},
        {vcmc_pkg::KIND_SEND,  4'd9,  31'd5, 1'b1, 1'b1, TOP, vcmc_pkg::ORD_BEFORE, 1'b0},
        {vcmc_pkg::KIND_RECV,  4'd15, 31'd0, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd7,  31'd1, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd3,  31'd9, 1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd5,  TOP,   1'b0, 1'b0, NO_WANT},
        {vcmc_pkg::KIND_RECV,  4'd0,  TOP,   1'b1, 1'b0, NO_WANT}
    };

    vector_clock_merge_compare dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic vcmc_pkg::t_count count_plus_one(input vcmc_pkg::t_count v);
        return (v == TOP) ? v : v + vcmc_pkg::t_count'(1);
    endfunction

    function automatic bit holds(input int id);
        return id < vcmc_pkg::NODES && (vc_seen[id] || id == int'(own_id));
    endfunction

    function automatic vcmc_pkg::t_count own_count();
        return (int'(own_id) < vcmc_pkg::NODES) ? vc_count[own_id] : vcmc_pkg::t_count'(0);
    endfunction

    // advance the clock by one item, returns 1 when the item yields a result
    function automatic bit advance_clock(input vcmc_pkg::t_in_item it,
                                         output vcmc_pkg::t_out_item res);
        vcmc_pkg::t_count rc;
        vcmc_pkg::t_count cur;
        int               id;
        res = '0;
        id  = int'(it.node_id);
        if (it.kind == vcmc_pkg::KIND_EVENT || it.kind == vcmc_pkg::KIND_SEND) begin
            if (int'(own_id) < vcmc_pkg::NODES) begin
                vc_count[own_id] = count_plus_one(vc_count[own_id]);
            end
            res.local_count = own_count();
            return 1'b1;
        end
        if (it.kind != vcmc_pkg::KIND_RECV) begin
            return 1'b0;
        end
        if (!in_run) begin
            base_present = 0;
            for (int i = 0; i < vcmc_pkg::NODES; i++) begin
                if (holds(i)) base_present++;
            end
            run_hits     = 0;
            mine_ahead   = 1'b0;
            theirs_ahead = 1'b0;
            in_run       = 1'b1;
        end
        rc = vcmc_pkg::t_count'(it.remote_count);
        if (id < vcmc_pkg::NODES) begin
            if (holds(id)) begin
                cur = vc_count[id];
                run_hits++;
                if (cur > rc) mine_ahead = 1'b1;
                else if (cur < rc) theirs_ahead = 1'b1;
                if (id == int'(own_id)) cur = count_plus_one(cur);
                vc_count[id] = (cur > rc) ? cur : rc;
            end else begin
                theirs_ahead = 1'b1;
                vc_count[id] = rc;
                vc_seen[id]  = 1'b1;
            end
        end
        if (!it.last) begin
            return 1'b0;
        end
        if (base_present > run_hits) mine_ahead = 1'b1;
        res.local_count = own_count();
        if (!mine_ahead) res.order = vcmc_pkg::ORD_BEFORE;
        else if (!theirs_ahead) res.order = vcmc_pkg::ORD_AFTER;
        else res.order = vcmc_pkg::ORD_CONC;
        res.is_receive = 1'b1;
        in_run = 1'b0;
        return 1'b1;
    endfunction

    function automatic vcmc_pkg::t_count pick_count(input int id, input bit big);
        longint v;
        int     r;
        int     off;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            off = int'($urandom_range(0, 4)) - 2;
            v   = longint'(vc_count[id]) + off;
            if (v < 0) v = 0;
            if (v > longint'(TOP)) v = longint'(TOP);
            return vcmc_pkg::t_count'(v);
        end
        if (r < 80) return vcmc_pkg::t_count'($urandom_range(0, 63));
        if (r < 95 || !big) return vcmc_pkg::t_count'($urandom);
        return TOP;
    endfunction

    task automatic issue(input vcmc_pkg::t_in_item it, input vcmc_pkg::t_out_item typed_want,
                         input bit typed);
        vcmc_pkg::t_out_item res;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (advance_clock(it, res)) begin
            due_results.push_back(typed ? typed_want : res);
            if (res.is_receive) runs_closed++;
        end
        if (it.kind != KIND_NONE) items_sent++;
        if (!calm && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic issue_local();
        vcmc_pkg::t_in_item it;
        it.kind         = $urandom_range(0, 1) ? vcmc_pkg::KIND_SEND : vcmc_pkg::KIND_EVENT;
        it.node_id      = vcmc_pkg::ID_W'($urandom);
        it.remote_count = vcmc_pkg::RC_W'($urandom);
        it.last         = 1'($urandom);
        issue(it, NO_WANT, 1'b0);
    endtask

    task automatic shuffle_ids();
        int j;
        int t;
        for (int i = run_ids.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = run_ids[i];
            run_ids[i] = run_ids[j];
            run_ids[j] = t;
        end
    endtask

    task automatic send_run(input bit echo, input bit big);
        vcmc_pkg::t_in_item it;
        int                 id;
        for (int k = 0; k < run_ids.size(); k++) begin
            if ($urandom_range(0, 99) < 8) issue_local();
            id              = run_ids[k];
            it.kind         = vcmc_pkg::KIND_RECV;
            it.node_id      = vcmc_pkg::ID_W'(id);
            it.remote_count = (echo && $urandom_range(0, 99) < 80) ? vc_count[id]
                                                                  : pick_count(id, big);
            it.last         = (k == run_ids.size() - 1);
            issue(it, NO_WANT, 1'b0);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        for (int w = 0; w < 200 && due_results.size() != 0; w++) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_owner(input logic [vcmc_pkg::ID_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        own_id = v;
        settings_used++;
    endtask

    always @(posedge i_clk) begin : check_results
        vcmc_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none due, actual %h", $time, o_result);
            end else begin
                want = due_results.pop_front();
                if (o_result.local_count !== want.local_count) begin
                    mismatches++;
                    $display("%0t: local_count expected %0d actual %0d",
                             $time, want.local_count, o_result.local_count);
                end
                if (o_result.order !== want.order) begin
                    mismatches++;
                    $display("%0t: order expected %0d actual %0d",
                             $time, want.order, o_result.order);
                end
                if (o_result.is_receive !== want.is_receive) begin
                    mismatches++;
                    $display("%0t: is_receive expected %0d actual %0d",
                             $time, want.is_receive, o_result.is_receive);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [vcmc_pkg::ID_W-1:0] owners [PHASES];
        int                        phase_items;
        int                        mode;
        int                        len;
        vcmc_pkg::t_in_item        it;

        owners = '{4'd15, 4'd6, 4'd0, vcmc_pkg::ID_W'($urandom), 4'd11, 4'd15};
        for (int i = 0; i < vcmc_pkg::NODES; i++) begin
            vc_count[i] = '0;
            vc_seen[i]  = 1'b0;
        end
        own_id        = '0;
        in_run        = 1'b0;
        base_present  = 0;
        run_hits      = 0;
        mine_ahead    = 1'b0;
        theirs_ahead  = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        runs_closed   = 0;
        settings_used = 1;
        calm          = 1'b0;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[s]) begin
            issue(steps[s].item, steps[s].want, steps[s].typed);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_owner(owners[p]);
            calm = (p == 1);
            phase_items = items_sent;
            while (items_sent - phase_items < PER_PHASE) begin
                mode = $urandom_range(0, 99);
                run_ids.delete();
                if (mode < 25) begin
                    issue_local();
                end else if (mode < 28) begin
                    it.kind         = KIND_NONE;
                    it.node_id      = vcmc_pkg::ID_W'($urandom);
                    it.remote_count = vcmc_pkg::RC_W'($urandom);
                    it.last         = 1'($urandom);
                    issue(it, NO_WANT, 1'b0);
                end else if (mode < 48) begin
                    // whole present vector sent back
                    for (int i = 0; i < vcmc_pkg::NODES; i++) begin
                        if (holds(i)) run_ids.push_back(i);
                    end
                    shuffle_ids();
                    send_run(1'b1, p == PHASES - 1);
                end else if (mode < 90) begin
                    len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                       : $urandom_range(1, vcmc_pkg::NODES);
                    for (int i = 0; i < vcmc_pkg::NODES; i++) run_ids.push_back(i);
                    shuffle_ids();
                    run_ids = run_ids[0:len-1];
                    send_run(1'b0, p == PHASES - 1);
                end else begin
                    // repeated ids in one vector
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        run_ids.push_back($urandom_range(0, vcmc_pkg::NODES - 1));
                    end
                    send_run(1'b0, p == PHASES - 1);
                end
            end
        end

        settle();
        if (due_results.size() != 0) begin
            mismatches += due_results.size();
            $display("%0t: %0d results never arrived", $time, due_results.size());
        end
        $display("ran %0d items under %0d owner ids, %0d results checked, %0d vectors closed",
                 items_sent, settings_used, results_seen, runs_closed);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
